### design/lbph_pkg.sv
`timescale 1ns / 1ps

package lbph_pkg;

	// Frame geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM    = 3;
	localparam int DIM_W      = 11;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 8;

	// Histogram
	localparam int NUM_BINS        = 10;
	localparam int BIN_W           = 4;
	localparam int COUNT_W         = 20;
	localparam int NONUNIFORM_CODE = 9;
	localparam int MAX_TRANSITIONS = 2;
	localparam int RING_N          = 8;

	// Queue between the classifier and the histogram
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [DIM_W-1:0]     DIM_RESET        = 11'd64;

	typedef struct packed {
		logic interior;
		logic first;
		logic last;
	} lbph_tag_t;

	typedef struct packed {
		lbph_tag_t        tag;
		logic [BIN_W-1:0] code;
	} lbph_item_t;

	// Texture code of one window: ones count if uniform, else the non-uniform code
	function automatic logic [BIN_W-1:0] lbp_code(input logic [RING_N-1:0][PIX_W-1:0] ring,
			input logic [PIX_W-1:0] centre);
		logic [RING_N-1:0] bits;
		logic [RING_N-1:0] diff;
		logic [BIN_W-1:0]  ones;
		logic [BIN_W-1:0]  trans;
		ones  = '0;
		trans = '0;
		for (int k = 0; k < RING_N; k++) begin
			bits[k] = (ring[k] >= centre);
		end
		diff = bits ^ {bits[RING_N-2:0], bits[RING_N-1]};
		for (int k = 0; k < RING_N; k++) begin
			ones  = ones + BIN_W'(bits[k]);
			trans = trans + BIN_W'(diff[k]);
		end
		if (trans > BIN_W'(MAX_TRANSITIONS)) begin
			return BIN_W'(NONUNIFORM_CODE);
		end
		return ones;
	endfunction

	// Clamp a dimension register to its legal range
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		if (v < DIM_W'(MIN_DIM)) begin
			return DIM_W'(MIN_DIM);
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

endpackage

### design/lbp_uniform_texture_histogram.sv
`timescale 1ns / 1ps

// Channel   | Handshake      | Payload
// ----------+----------------+--------------------------------------
// pixels in | push / full    | pixel_value[7:0]
// bins out  | pop / empty    | bin_index[3:0], bin_count[19:0], last_bin
// config    | wr_en          | wr_index[0], wr_data[10:0]
//
// One pixel per cycle is taken in steady state; each passes a two-stage
// classifier (line store read, window shift, code) and a four-entry queue.
// After a frame's last pixel the histogram unit emits ten bins, at most one
// per cycle, and holds the queue meanwhile, so input stalls once it fills.
// Reset is asynchronous; line stores are not cleared and need no sweep.

module lbp_uniform_texture_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lbph_pkg::PIX_W-1:0]     pixel_value,
	output logic                          empty,
	input  logic                          pop,
	output logic [lbph_pkg::BIN_W-1:0]     bin_index,
	output logic [lbph_pkg::COUNT_W-1:0]   bin_count,
	output logic                          last_bin,
	input  logic                          wr_en,
	input  logic [lbph_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [lbph_pkg::DIM_W-1:0]     wr_data
);

	import lbph_pkg::*;

	logic       q_push, q_pop, q_valid;
	lbph_item_t q_wr_item, q_rd_item;

	lbph_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel_value (pixel_value),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.q_pop       (q_pop),
		.q_push      (q_push),
		.q_item      (q_wr_item)
	);

	lbph_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_item  (q_wr_item),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	lbph_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_rd_item),
		.item_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.bin_index  (bin_index),
		.bin_count  (bin_count),
		.last_bin   (last_bin)
	);

endmodule

### design/lbph_ram.sv
`timescale 1ns / 1ps

module lbph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/lbph_front.sv
`timescale 1ns / 1ps

module lbph_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lbph_pkg::PIX_W-1:0]     pixel_value,
	input  logic                          wr_en,
	input  logic [lbph_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [lbph_pkg::DIM_W-1:0]     wr_data,
	input  logic                          q_pop,
	output logic                          q_push,
	output lbph_pkg::lbph_item_t          q_item
);

	import lbph_pkg::*;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [QCNT_W-1:0] credit_q;
	logic              accept;
	logic              row_end, frame_end;
	lbph_tag_t         tag_in;

	logic              v_s1;
	logic [PIX_W-1:0]  px_s1;
	logic [COL_W-1:0]  col_s1;
	lbph_tag_t         tag_s1;
	logic [PIX_W-1:0]  upper_rd, middle_rd;

	logic [PIX_W-1:0]  win_q [3][3];
	logic              v_s2;
	lbph_tag_t         tag_s2;
	logic [RING_N-1:0][PIX_W-1:0] ring;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
	assign h_eff = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));

	// Hold off input while every queue slot is spoken for
	assign full   = (credit_q >= QCNT_W'(QUEUE_DEPTH));
	assign accept = push && !full;

	assign row_end   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign frame_end = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= h_eff);

	always_comb begin
		tag_in.interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		tag_in.first    = (col_q == '0) && (row_q == '0);
		tag_in.last     = frame_end;
	end

	// Count items between input and queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, q_pop})
				2'b10:   credit_q <= credit_q + QCNT_W'(1);
				2'b01:   credit_q <= credit_q - QCNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1: line stores are read at the current column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= pixel_value;
			col_s1 <= col_q;
			tag_s1 <= tag_in;
		end
	end

	lbph_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (middle_rd),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	lbph_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (px_s1),
		.raddr (col_q),
		.rdata (middle_rd)
	);

	// Shift the 3x3 window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= upper_rd;
			win_q[1][2] <= middle_rd;
			win_q[2][2] <= px_s1;
		end
	end

	// Stage 2: classify the window and hand it to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			tag_s2 <= tag_s1;
		end
	end

	// Ring order: upper right, right, lower right, below, lower left, left, upper left, above
	always_comb begin
		ring[0] = win_q[0][2];
		ring[1] = win_q[1][2];
		ring[2] = win_q[2][2];
		ring[3] = win_q[2][1];
		ring[4] = win_q[2][0];
		ring[5] = win_q[1][0];
		ring[6] = win_q[0][0];
		ring[7] = win_q[0][1];
	end

	assign q_push      = v_s2;
	assign q_item.tag  = tag_s2;
	assign q_item.code = lbp_code(ring, win_q[1][1]);

endmodule

### design/lbph_fifo.sv
`timescale 1ns / 1ps

module lbph_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lbph_pkg::lbph_item_t wr_item,
	input  logic                 pop,
	output logic                 rd_valid,
	output lbph_pkg::lbph_item_t rd_item
);

	import lbph_pkg::*;

	lbph_item_t        slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign do_push  = push && (count_q < QCNT_W'(QUEUE_DEPTH));
	assign do_pop   = pop && (count_q != '0);
	assign rd_valid = (count_q != '0);
	assign rd_item  = slots_q[rd_ptr_q];

	// Store incoming items
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/lbph_back.sv
`timescale 1ns / 1ps

module lbph_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  lbph_pkg::lbph_item_t        item,
	output logic                        item_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [lbph_pkg::BIN_W-1:0]   bin_index,
	output logic [lbph_pkg::COUNT_W-1:0] bin_count,
	output logic                        last_bin
);

	import lbph_pkg::*;

	logic [COUNT_W-1:0] hist_q [NUM_BINS];
	logic               emit_q;
	logic [BIN_W-1:0]   idx_q;
	logic               out_valid_q;
	logic               load;

	// Take items only while no histogram dump is running
	assign item_pop = item_valid && !emit_q;
	assign load     = emit_q && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// Clear on a frame's first pixel, count interior codes, saturate at the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (item_pop) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				if (item.tag.first) begin
					hist_q[i] <= '0;
				end else if (item.tag.interior && (item.code == BIN_W'(i))
						&& (hist_q[i] != '1)) begin
					hist_q[i] <= hist_q[i] + COUNT_W'(1);
				end
			end
		end
	end

	// Dump sequencer: one bin per transaction after the frame's last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			idx_q  <= '0;
		end else if (item_pop && item.tag.last) begin
			emit_q <= 1'b1;
			idx_q  <= '0;
		end else if (load) begin
			idx_q <= idx_q + BIN_W'(1);
			if (idx_q == BIN_W'(NUM_BINS - 1)) begin
				emit_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_index <= idx_q;
			bin_count <= hist_q[idx_q];
			last_bin  <= (idx_q == BIN_W'(NUM_BINS - 1));
		end
	end

endmodule

### design/lbph_checker.sv
`timescale 1ns / 1ps

module lbph_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [lbph_pkg::BIN_W-1:0]   bin_index,
	input logic [lbph_pkg::COUNT_W-1:0] bin_count,
	input logic                        last_bin
);

	import lbph_pkg::*;

	// Bin numbers stay within the histogram
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (bin_index < BIN_W'(NUM_BINS)))
		else $error("bin index beyond histogram");

	// The final flag marks the top bin and nothing else
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_bin == (bin_index == BIN_W'(NUM_BINS - 1))))
		else $error("last flag disagrees with bin index");

	// Once a dump starts, bins follow one another without gaps
	a_bin_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_bin) |=>
		(!empty && (bin_index == $past(bin_index) + BIN_W'(1))))
		else $error("histogram dump skipped or repeated a bin");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(bin_index) && $stable(bin_count)))
		else $error("result changed while stalled");

endmodule

bind lbp_uniform_texture_histogram lbph_checker u_lbph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.bin_index (bin_index),
	.bin_count (bin_count),
	.last_bin  (last_bin)
);
